### src/lav_pkg.sv
// Shared constants and types for the look-at view matrix pipeline.
package lav_pkg;

	localparam int WORD_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int AXIS_W     = FRAC_W + 2;
	localparam int QUO_W      = FRAC_W + 1;
	localparam int MAG_W      = 48;
	localparam int LEAD_W     = 6;
	localparam int SCL_W      = 30;
	localparam int SCL_LEAD   = SCL_W - 1;
	localparam int SH_W       = 5;
	localparam int SQ_W       = 2 * SCL_W;
	localparam int SUM_W      = SQ_W + 2;
	localparam int RT_W       = SUM_W + 1;
	localparam int SQRT_STEPS = 32;
	localparam int DEN_W      = 32;
	localparam int REM_W      = 48;
	localparam int SCALE_LAT  = 3;
	localparam int NORM_LAT   = SCALE_LAT + 2 + SQRT_STEPS + QUO_W + 1;

	localparam logic [QUO_W-1:0] AXIS_ONE = QUO_W'(1) << FRAC_W;

	typedef struct packed {
		logic                   valid;
		logic [2:0]             neg;
		logic [2:0][MAG_W-1:0]  mag;
	} nin_t;

	typedef struct packed {
		logic                   valid;
		logic                   zero;
		logic [2:0]             neg;
		logic [2:0][SCL_W-1:0]  mag;
	} scl_t;

	typedef struct packed {
		logic                   valid;
		logic [2:0][AXIS_W-1:0] axis;
	} nout_t;

endpackage

### src/lav_scale.sv
// Three-stage block scaling of a sign-magnitude vector so its largest magnitude lands in [2^29, 2^30).
module lav_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  lav_pkg::nin_t din,
	output lav_pkg::scl_t dout
);

	logic                                  valid_s1, valid_s2, valid_s3;
	logic [2:0]                            neg_s1, neg_s2, neg_s3;
	logic [2:0][lav_pkg::MAG_W-1:0]        mag_s1, mag_s2;
	logic [lav_pkg::MAG_W-1:0]             top_s1;
	logic                                  zero_s2, zero_s3;
	logic                                  rsh_s2;
	logic [lav_pkg::SH_W-1:0]              amt_s2;
	logic [2:0][lav_pkg::SCL_W-1:0]        mag_s3;

	logic [lav_pkg::MAG_W-1:0]             top_c;
	logic [lav_pkg::LEAD_W-1:0]            lead_c;
	logic                                  rsh_c;
	logic [lav_pkg::SH_W-1:0]              amt_c;

	always_comb begin
		top_c = din.mag[0];
		if (din.mag[1] > top_c) top_c = din.mag[1];
		if (din.mag[2] > top_c) top_c = din.mag[2];
	end

	always_comb begin
		lead_c = '0;
		for (int i = 0; i < lav_pkg::MAG_W; i++) begin
			if (top_s1[i]) lead_c = lav_pkg::LEAD_W'(i);
		end
		if (int'(lead_c) > lav_pkg::SCL_LEAD) begin
			rsh_c = 1'b1;
			amt_c = lav_pkg::SH_W'(int'(lead_c) - lav_pkg::SCL_LEAD);
		end else begin
			rsh_c = 1'b0;
			amt_c = lav_pkg::SH_W'(lav_pkg::SCL_LEAD - int'(lead_c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= din.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1  <= din.neg;
		mag_s1  <= din.mag;
		top_s1  <= top_c;
		neg_s2  <= neg_s1;
		mag_s2  <= mag_s1;
		zero_s2 <= (top_s1 == '0);
		rsh_s2  <= rsh_c;
		amt_s2  <= amt_c;
		neg_s3  <= neg_s2;
		zero_s3 <= zero_s2;
		for (int i = 0; i < 3; i++) begin
			// right shift truncates, left shift is exact
			mag_s3[i] <= rsh_s2 ? lav_pkg::SCL_W'(mag_s2[i] >> amt_s2)
			                    : lav_pkg::SCL_W'(mag_s2[i] << amt_s2);
		end
	end

	assign dout = '{valid: valid_s3, zero: zero_s3, neg: neg_s3, mag: mag_s3};

endmodule

### src/lav_norm.sv
// Pipelined vector normalizer: block scale, sum of squares, bit-serial root, restoring divide.
module lav_norm (
	input  logic           clk,
	input  logic           arst_n,
	input  lav_pkg::nin_t  din,
	output lav_pkg::nout_t dout
);

	typedef struct packed {
		logic                           zero;
		logic [2:0]                     neg;
		logic [2:0][lav_pkg::SCL_W-1:0] mag;
		logic [lav_pkg::RT_W-1:0]       x;
		logic [lav_pkg::RT_W-1:0]       r;
	} sqrt_t;

	typedef struct packed {
		logic                           zero;
		logic [2:0]                     neg;
		logic [lav_pkg::DEN_W-1:0]      den;
		logic [2:0][lav_pkg::REM_W-1:0] rem;
		logic [2:0][lav_pkg::QUO_W-1:0] quo;
	} div_t;

	lav_pkg::scl_t                   scl;
	logic                            valid_s4, valid_s5, valid_s6;
	logic                            zero_s4, zero_s5;
	logic [2:0]                      neg_s4, neg_s5;
	logic [2:0][lav_pkg::SCL_W-1:0]  mag_s4, mag_s5;
	logic [2:0][lav_pkg::SQ_W-1:0]   sq_s4;
	logic [lav_pkg::SUM_W-1:0]       sum_s5;
	logic [2:0][lav_pkg::AXIS_W-1:0] axis_s6;

	sqrt_t sqrt_s  [lav_pkg::SQRT_STEPS];
	logic  sqrtv_s [lav_pkg::SQRT_STEPS];
	div_t  div_s   [lav_pkg::QUO_W];
	logic  divv_s  [lav_pkg::QUO_W];

	lav_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (scl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s4 <= scl.valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		zero_s4 <= scl.zero;
		neg_s4  <= scl.neg;
		mag_s4  <= scl.mag;
		for (int i = 0; i < 3; i++) sq_s4[i] <= scl.mag[i] * scl.mag[i];
		zero_s5 <= zero_s4;
		neg_s5  <= neg_s4;
		mag_s5  <= mag_s4;
		sum_s5  <= lav_pkg::SUM_W'(sq_s4[0]) + lav_pkg::SUM_W'(sq_s4[1])
		         + lav_pkg::SUM_W'(sq_s4[2]);
	end

	// one root bit per stage
	for (genvar k = 0; k < lav_pkg::SQRT_STEPS; k++) begin : g_sqrt
		sqrt_t                    prev, nxt;
		logic                     pv;
		logic [lav_pkg::RT_W-1:0] bitv, trial;

		if (k == 0) begin : g_first
			assign prev = '{zero: zero_s5, neg: neg_s5, mag: mag_s5,
			                x: lav_pkg::RT_W'(sum_s5), r: '0};
			assign pv   = valid_s5;
		end else begin : g_next
			assign prev = sqrt_s[k-1];
			assign pv   = sqrtv_s[k-1];
		end

		assign bitv = lav_pkg::RT_W'(1) << (2 * (lav_pkg::SQRT_STEPS - 1 - k));

		always_comb begin
			nxt   = prev;
			trial = prev.r + bitv;
			if (prev.x >= trial) begin
				nxt.x = prev.x - trial;
				nxt.r = (prev.r >> 1) + bitv;
			end else begin
				nxt.r = prev.r >> 1;
			end
		end

		always_ff @(posedge clk) sqrt_s[k] <= nxt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqrtv_s[k] <= 1'b0;
			else         sqrtv_s[k] <= pv;
		end
	end

	// one quotient bit per stage, three lanes share the divisor
	for (genvar j = 0; j < lav_pkg::QUO_W; j++) begin : g_div
		div_t                      prev, nxt;
		logic                      pv;
		logic [lav_pkg::REM_W-1:0] dsh;

		if (j == 0) begin : g_first
			sqrt_t last;
			assign last = sqrt_s[lav_pkg::SQRT_STEPS-1];
			always_comb begin
				prev.zero = last.zero;
				prev.neg  = last.neg;
				prev.den  = lav_pkg::DEN_W'(last.r);
				prev.quo  = '0;
				for (int i = 0; i < 3; i++) begin
					prev.rem[i] = (lav_pkg::REM_W'(last.mag[i]) << lav_pkg::FRAC_W)
					            + lav_pkg::REM_W'(last.r >> 1);
				end
			end
			assign pv = sqrtv_s[lav_pkg::SQRT_STEPS-1];
		end else begin : g_next
			assign prev = div_s[j-1];
			assign pv   = divv_s[j-1];
		end

		assign dsh = lav_pkg::REM_W'(prev.den) << (lav_pkg::QUO_W - 1 - j);

		always_comb begin
			nxt = prev;
			for (int i = 0; i < 3; i++) begin
				if (prev.rem[i] >= dsh) begin
					nxt.rem[i] = prev.rem[i] - dsh;
					nxt.quo[i][lav_pkg::QUO_W-1-j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) div_s[j] <= nxt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) divv_s[j] <= 1'b0;
			else         divv_s[j] <= pv;
		end
	end

	div_t                            dlast;
	logic [2:0][lav_pkg::AXIS_W-1:0] axis_c;

	assign dlast = div_s[lav_pkg::QUO_W-1];

	always_comb begin
		logic [lav_pkg::QUO_W-1:0] q;
		for (int i = 0; i < 3; i++) begin
			q = dlast.quo[i];
			if (q > lav_pkg::AXIS_ONE) q = lav_pkg::AXIS_ONE;
			if (dlast.zero)        axis_c[i] = '0;
			else if (dlast.neg[i]) axis_c[i] = -lav_pkg::AXIS_W'(q);
			else                   axis_c[i] = lav_pkg::AXIS_W'(q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s6 <= 1'b0;
		else         valid_s6 <= divv_s[lav_pkg::QUO_W-1];
	end

	always_ff @(posedge clk) axis_s6 <= axis_c;

	assign dout = '{valid: valid_s6, axis: axis_s6};

endmodule

### src/look_at_view_matrix.sv
// Top level: left-handed look-at view matrix, fully pipelined, one camera item per cycle.
//
//   channel   handshake        payload
//   in        start / busy     eye_*, target_*, upref_*  (signed Q16.16)
//   out       done strobe      right_*, upaxis_*, gaze_* (signed Q2.16, 18 bit),
//                              shift_right, shift_up, shift_gaze (Q16.16, 32 bit)
//
// An item is taken on every edge with start high; busy never rises.
// Each result appears for one cycle, with done high.
// The latency is set by the two normalizers in series (55 stages each, one root bit or one
// quotient bit per stage in their root and divide steps) plus the input, cross, up-axis and translation stages.
// Reset clears only the valid bits; data registers run free.
module look_at_view_matrix (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [lav_pkg::WORD_W-1:0]   eye_x,
	input  logic signed [lav_pkg::WORD_W-1:0]   eye_y,
	input  logic signed [lav_pkg::WORD_W-1:0]   eye_z,
	input  logic signed [lav_pkg::WORD_W-1:0]   target_x,
	input  logic signed [lav_pkg::WORD_W-1:0]   target_y,
	input  logic signed [lav_pkg::WORD_W-1:0]   target_z,
	input  logic signed [lav_pkg::WORD_W-1:0]   upref_x,
	input  logic signed [lav_pkg::WORD_W-1:0]   upref_y,
	input  logic signed [lav_pkg::WORD_W-1:0]   upref_z,
	output logic                                done,
	output logic signed [lav_pkg::AXIS_W-1:0]   right_x,
	output logic signed [lav_pkg::AXIS_W-1:0]   right_y,
	output logic signed [lav_pkg::AXIS_W-1:0]   right_z,
	output logic signed [lav_pkg::AXIS_W-1:0]   upaxis_x,
	output logic signed [lav_pkg::AXIS_W-1:0]   upaxis_y,
	output logic signed [lav_pkg::AXIS_W-1:0]   upaxis_z,
	output logic signed [lav_pkg::AXIS_W-1:0]   gaze_x,
	output logic signed [lav_pkg::AXIS_W-1:0]   gaze_y,
	output logic signed [lav_pkg::AXIS_W-1:0]   gaze_z,
	output logic signed [lav_pkg::WORD_W-1:0]   shift_right,
	output logic signed [lav_pkg::WORD_W-1:0]   shift_up,
	output logic signed [lav_pkg::WORD_W-1:0]   shift_gaze
);

	localparam int W       = lav_pkg::WORD_W;
	localparam int AW      = lav_pkg::AXIS_W;
	localparam int FW      = lav_pkg::FRAC_W;
	localparam int DW      = W + 1;
	localparam int UW      = lav_pkg::SCL_W + 1;
	localparam int CP_W    = UW + AW;
	localparam int C_W     = CP_W + 1;
	localparam int VP_W    = 2 * AW;
	localparam int VD_W    = VP_W + 1;
	localparam int VQ_W    = VD_W - FW;
	localparam int PROD_W  = AW + W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int RND_W   = ACC_W + 1;
	localparam int SHR_W   = RND_W - FW;
	localparam int UP_DLY  = lav_pkg::NORM_LAT - lav_pkg::SCALE_LAT;
	localparam int G_DLY   = lav_pkg::NORM_LAT + 2;
	localparam int EYE_DLY = 2 * lav_pkg::NORM_LAT + 2;

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	logic signed [2:0][W-1:0] eye_a, tgt_a, upr_a;
	assign eye_a = {eye_z, eye_y, eye_x};
	assign tgt_a = {target_z, target_y, target_x};
	assign upr_a = {upref_z, upref_y, upref_x};

	// stage 1: gaze difference and magnitudes
	logic                   valid_s1;
	logic [2:0]             dneg_s1, uneg_s1;
	logic [2:0][DW-1:0]     dmag_s1;
	logic [2:0][W-1:0]      umag_s1;
	logic [2:0][W-1:0]      eye_s1;

	logic [2:0]             dneg_c, uneg_c;
	logic [2:0][DW-1:0]     dmag_c;
	logic [2:0][W-1:0]      umag_c;

	always_comb begin
		logic signed [DW-1:0] dif, uw;
		for (int i = 0; i < 3; i++) begin
			dif       = $signed({tgt_a[i][W-1], tgt_a[i]}) - $signed({eye_a[i][W-1], eye_a[i]});
			dneg_c[i] = dif[DW-1];
			dmag_c[i] = dneg_c[i] ? DW'(-dif) : DW'(dif);
			uw        = $signed({upr_a[i][W-1], upr_a[i]});
			uneg_c[i] = uw[DW-1];
			umag_c[i] = uneg_c[i] ? W'(-uw) : W'(uw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		dneg_s1 <= dneg_c;
		dmag_s1 <= dmag_c;
		uneg_s1 <= uneg_c;
		umag_s1 <= umag_c;
		eye_s1  <= eye_a;
	end

	// gaze normalizer and reference-up scaling
	lav_pkg::nin_t  gin, uin, rin;
	lav_pkg::nout_t gn, rn;
	lav_pkg::scl_t  us;

	always_comb begin
		gin.valid = valid_s1;
		gin.neg   = dneg_s1;
		uin.valid = valid_s1;
		uin.neg   = uneg_s1;
		for (int i = 0; i < 3; i++) begin
			gin.mag[i] = lav_pkg::MAG_W'(dmag_s1[i]);
			uin.mag[i] = lav_pkg::MAG_W'(umag_s1[i]);
		end
	end

	lav_norm u_gaze_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (gin),
		.dout   (gn)
	);

	lav_scale u_up_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (uin),
		.dout   (us)
	);

	logic [2:0][UW-1:0] us_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			us_c[i] = us.neg[i] ? -UW'(us.mag[i]) : UW'(us.mag[i]);
		end
	end

	// hold payload until the matching normalizer output appears
	logic [2:0][UW-1:0] up_q  [UP_DLY];
	logic [2:0][AW-1:0] g_q   [G_DLY];
	logic [2:0][W-1:0]  eye_q [EYE_DLY];

	always_ff @(posedge clk) begin
		up_q[0]  <= us_c;
		g_q[0]   <= gn.axis;
		eye_q[0] <= eye_s1;
		for (int k = 1; k < UP_DLY; k++)  up_q[k]  <= up_q[k-1];
		for (int k = 1; k < G_DLY; k++)   g_q[k]   <= g_q[k-1];
		for (int k = 1; k < EYE_DLY; k++) eye_q[k] <= eye_q[k-1];
	end

	// stages 2-3: cross products of scaled up and gaze, then sign and magnitude
	logic                   valid_s2, valid_s3;
	logic [5:0][CP_W-1:0]   cp_s2;
	logic [2:0]             cneg_s3;
	logic [2:0][lav_pkg::MAG_W-1:0] cmag_s3;

	logic [2:0][UW-1:0] u_c;
	logic [2:0][AW-1:0] g_c;
	assign u_c = up_q[UP_DLY-1];
	assign g_c = gn.axis;

	logic [2:0][C_W-1:0] c_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_c[i] = C_W'($signed(cp_s2[2*i])) - C_W'($signed(cp_s2[2*i+1]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= gn.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cp_s2[0] <= CP_W'($signed(u_c[1]) * $signed(g_c[2]));
		cp_s2[1] <= CP_W'($signed(u_c[2]) * $signed(g_c[1]));
		cp_s2[2] <= CP_W'($signed(u_c[2]) * $signed(g_c[0]));
		cp_s2[3] <= CP_W'($signed(u_c[0]) * $signed(g_c[2]));
		cp_s2[4] <= CP_W'($signed(u_c[0]) * $signed(g_c[1]));
		cp_s2[5] <= CP_W'($signed(u_c[1]) * $signed(g_c[0]));
		for (int i = 0; i < 3; i++) begin
			cneg_s3[i] <= c_c[i][C_W-1];
			cmag_s3[i] <= c_c[i][C_W-1] ? lav_pkg::MAG_W'(-c_c[i])
			                            : lav_pkg::MAG_W'(c_c[i]);
		end
	end

	assign rin = '{valid: valid_s3, neg: cneg_s3, mag: cmag_s3};

	lav_norm u_right_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (rin),
		.dout   (rn)
	);

	// stages 4-6: up axis = gaze x right, rounded
	logic                 valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic [2:0][AW-1:0]   r_s4, g_s4, r_s5, g_s5, r_s6, g_s6, v_s6;
	logic [2:0][AW-1:0]   r_s7, g_s7, v_s7, r_s8, g_s8, v_s8;
	logic [2:0][W-1:0]    eye_s4, eye_s5, eye_s6;
	logic [5:0][VP_W-1:0] vp_s4;
	logic [2:0]           vneg_s5;
	logic [2:0][VD_W-1:0] vmag_s5;
	logic [2:0][2:0][PROD_W-1:0] tp_s7;
	logic [2:0][ACC_W-1:0]       acc_s8;

	logic [2:0][AW-1:0] r_c;
	assign r_c = rn.axis;

	logic [2:0][AW-1:0] gd_c;
	assign gd_c = g_q[G_DLY-1];

	logic [2:0][VD_W-1:0] vd_c;
	logic [2:0][AW-1:0]   v_c;
	always_comb begin
		logic [VD_W-1:0] vr;
		logic [VQ_W-1:0] vq;
		for (int i = 0; i < 3; i++) begin
			vd_c[i] = VD_W'($signed(vp_s4[2*i])) - VD_W'($signed(vp_s4[2*i+1]));
			vr      = vmag_s5[i] + VD_W'(1 << (FW - 1));
			vq      = vr[VD_W-1:FW];
			if (vq > VQ_W'(lav_pkg::AXIS_ONE)) vq = VQ_W'(lav_pkg::AXIS_ONE);
			v_c[i]  = vneg_s5[i] ? -AW'(vq) : AW'(vq);
		end
	end

	// stages 7-8 and output: translations = -(axis . eye), rounded and saturated
	logic [2:0][2:0][AW-1:0] ax_c;
	assign ax_c = {g_s6, v_s6, r_s6};

	logic [2:0][W-1:0] tr_c;
	always_comb begin
		logic signed [RND_W-1:0] y;
		logic [SHR_W-1:0]        sh;
		for (int k = 0; k < 3; k++) begin
			y  = $signed(RND_W'(1 << (FW - 1))) - $signed({acc_s8[k][ACC_W-1], acc_s8[k]});
			sh = y[RND_W-1:FW];
			if ((&sh[SHR_W-1:W-1]) || !(|sh[SHR_W-1:W-1])) tr_c[k] = sh[W-1:0];
			else if (sh[SHR_W-1])                         tr_c[k] = {1'b1, {(W-1){1'b0}}};
			else                                          tr_c[k] = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s4 <= rn.valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			done     <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		r_s4     <= r_c;
		g_s4     <= gd_c;
		eye_s4   <= eye_q[EYE_DLY-1];
		vp_s4[0] <= VP_W'($signed(gd_c[1]) * $signed(r_c[2]));
		vp_s4[1] <= VP_W'($signed(gd_c[2]) * $signed(r_c[1]));
		vp_s4[2] <= VP_W'($signed(gd_c[2]) * $signed(r_c[0]));
		vp_s4[3] <= VP_W'($signed(gd_c[0]) * $signed(r_c[2]));
		vp_s4[4] <= VP_W'($signed(gd_c[0]) * $signed(r_c[1]));
		vp_s4[5] <= VP_W'($signed(gd_c[1]) * $signed(r_c[0]));

		r_s5   <= r_s4;
		g_s5   <= g_s4;
		eye_s5 <= eye_s4;
		for (int i = 0; i < 3; i++) begin
			vneg_s5[i] <= vd_c[i][VD_W-1];
			vmag_s5[i] <= vd_c[i][VD_W-1] ? -vd_c[i] : vd_c[i];
		end

		r_s6   <= r_s5;
		g_s6   <= g_s5;
		v_s6   <= v_c;
		eye_s6 <= eye_s5;

		r_s7 <= r_s6;
		g_s7 <= g_s6;
		v_s7 <= v_s6;
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				tp_s7[k][i] <= PROD_W'($signed(ax_c[k][i]) * $signed(eye_s6[i]));
			end
		end

		r_s8 <= r_s7;
		g_s8 <= g_s7;
		v_s8 <= v_s7;
		for (int k = 0; k < 3; k++) begin
			acc_s8[k] <= ACC_W'($signed(tp_s7[k][0])) + ACC_W'($signed(tp_s7[k][1]))
			           + ACC_W'($signed(tp_s7[k][2]));
		end

		right_x     <= r_s8[0];
		right_y     <= r_s8[1];
		right_z     <= r_s8[2];
		upaxis_x    <= v_s8[0];
		upaxis_y    <= v_s8[1];
		upaxis_z    <= v_s8[2];
		gaze_x      <= g_s8[0];
		gaze_y      <= g_s8[1];
		gaze_z      <= g_s8[2];
		shift_right <= tr_c[0];
		shift_up    <= tr_c[1];
		shift_gaze  <= tr_c[2];
	end

endmodule

### dv/tb.sv
// Self-checking testbench for the look-at view matrix pipeline.
`timescale 1ns / 100ps

module tb;

	typedef longint unsigned u3_t[3];
	typedef longint s3_t[3];

	typedef struct {
		logic signed [lav_pkg::WORD_W-1:0] e[3];
		logic signed [lav_pkg::WORD_W-1:0] t[3];
		logic signed [lav_pkg::WORD_W-1:0] u[3];
		bit drain;
	} camera_t;

	typedef struct {
		logic signed [lav_pkg::AXIS_W-1:0] r[3];
		logic signed [lav_pkg::AXIS_W-1:0] v[3];
		logic signed [lav_pkg::AXIS_W-1:0] g[3];
		logic signed [lav_pkg::WORD_W-1:0] sh[3];
	} view_t;

	logic clk = 0, arst_n = 0, start = 0;
	logic busy, done;
	logic signed [lav_pkg::WORD_W-1:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [lav_pkg::WORD_W-1:0] target_x = 0, target_y = 0, target_z = 0;
	logic signed [lav_pkg::WORD_W-1:0] upref_x = 0, upref_y = 0, upref_z = 0;
	logic signed [lav_pkg::AXIS_W-1:0] right_x, right_y, right_z;
	logic signed [lav_pkg::AXIS_W-1:0] upaxis_x, upaxis_y, upaxis_z;
	logic signed [lav_pkg::AXIS_W-1:0] gaze_x, gaze_y, gaze_z;
	logic signed [lav_pkg::WORD_W-1:0] shift_right, shift_up, shift_gaze;

	camera_t pending[$];
	view_t views_due[$];
	int errors = 0;
	int gap = 0;
	bit stim_done = 0;

	look_at_view_matrix DUT (.*);

	always #5 clk = ~clk;

	// shift the three magnitudes together so the largest lands in [2^29, 2^30)
	function automatic bit block_fit(ref u3_t m);
		longint unsigned top;
		top = m[0];
		if (m[1] > top) top = m[1];
		if (m[2] > top) top = m[2];
		if (top == 0) return 0;
		while (top >= (64'd1 << 30)) begin
			top >>= 1;
			foreach (m[i]) m[i] >>= 1;
		end
		while (top < (64'd1 << 29)) begin
			top <<= 1;
			foreach (m[i]) m[i] <<= 1;
		end
		return 1;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic s3_t unit_vec(s3_t a);
		u3_t m;
		s3_t o;
		longint unsigned s, n, q;
		foreach (a[i]) m[i] = a[i] < 0 ? -a[i] : a[i];
		o = '{0, 0, 0};
		if (!block_fit(m)) return o;
		s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		n = floor_sqrt(s);
		foreach (m[i]) begin
			q = ((m[i] << lav_pkg::FRAC_W) + n / 2) / n;
			if (q > (64'd1 << lav_pkg::FRAC_W)) q = 64'd1 << lav_pkg::FRAC_W;
			o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
		end
		return o;
	endfunction

	function automatic longint round_axis(longint x);
		longint unsigned m;
		m = x < 0 ? -x : x;
		m = (m + (64'd1 << (lav_pkg::FRAC_W - 1))) >> lav_pkg::FRAC_W;
		if (m > (64'd1 << lav_pkg::FRAC_W)) m = 64'd1 << lav_pkg::FRAC_W;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [lav_pkg::WORD_W-1:0] eye_shift(s3_t ax, camera_t c);
		longint acc;
		acc = 0;
		foreach (ax[i]) acc += ax[i] * longint'(c.e[i]);
		acc = (-acc + (64'sd1 <<< (lav_pkg::FRAC_W - 1))) >>> lav_pkg::FRAC_W;
		if (acc > 64'sh7fffffff) return 32'sh7fffffff;
		if (acc < -64'sh80000000) return 32'sh80000000;
		return acc[lav_pkg::WORD_W-1:0];
	endfunction

	function automatic view_t view_of(camera_t c);
		s3_t d, g, up, cr, r, v;
		u3_t um;
		view_t o;
		foreach (d[i]) d[i] = longint'(c.t[i]) - longint'(c.e[i]);
		g = unit_vec(d);
		foreach (um[i]) um[i] = c.u[i] < 0 ? -longint'(c.u[i]) : longint'(c.u[i]);
		void'(block_fit(um));
		foreach (up[i]) up[i] = c.u[i] < 0 ? -longint'(um[i]) : longint'(um[i]);
		cr[0] = up[1] * g[2] - up[2] * g[1];
		cr[1] = up[2] * g[0] - up[0] * g[2];
		cr[2] = up[0] * g[1] - up[1] * g[0];
		r = unit_vec(cr);
		v[0] = round_axis(g[1] * r[2] - g[2] * r[1]);
		v[1] = round_axis(g[2] * r[0] - g[0] * r[2]);
		v[2] = round_axis(g[0] * r[1] - g[1] * r[0]);
		for (int i = 0; i < 3; i++) begin
			o.r[i] = r[i][lav_pkg::AXIS_W-1:0];
			o.v[i] = v[i][lav_pkg::AXIS_W-1:0];
			o.g[i] = g[i][lav_pkg::AXIS_W-1:0];
		end
		o.sh[0] = eye_shift(r, c);
		o.sh[1] = eye_shift(v, c);
		o.sh[2] = eye_shift(g, c);
		return o;
	endfunction

	function automatic logic signed [lav_pkg::WORD_W-1:0] rand_coord(int kind);
		case (kind)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h01000000)) - 32'sh00800000;
			2: return $signed($urandom_range(0, 64)) - 32;
			default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	task automatic add_camera(logic signed [lav_pkg::WORD_W-1:0] e[3],
			logic signed [lav_pkg::WORD_W-1:0] t[3],
			logic signed [lav_pkg::WORD_W-1:0] u[3], bit drain = 0);
		camera_t c;
		c.e = e;
		c.t = t;
		c.u = u;
		c.drain = drain;
		pending.push_back(c);
	endtask

	initial begin
		logic signed [lav_pkg::WORD_W-1:0] e[3], t[3], u[3];
		int k;
		// directed: identity setup, eye on target, up along gaze, zero up, extremes
		add_camera('{0, 0, 0}, '{0, 0, 32'sh10000}, '{0, 32'sh10000, 0});
		add_camera('{32'sh30000, 5, -7}, '{32'sh30000, 5, -7}, '{0, 32'sh10000, 0});
		add_camera('{0, 0, 0}, '{0, 32'sh20000, 0}, '{0, 32'sh10000, 0});
		add_camera('{1, 2, 3}, '{4, 5, 6}, '{0, 0, 0});
		add_camera('{32'sh80000000, 32'sh80000000, 32'sh80000000},
			'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, '{32'sh7fffffff, 0, 32'sh80000000});
		add_camera('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff},
			'{32'sh80000000, 32'sh80000000, 32'sh80000000}, '{32'sh80000000, 32'sh7fffffff, 0});
		add_camera('{32'sh80000000, 0, 0}, '{32'sh7fffffff, 0, 0}, '{0, 32'sh80000000, 0});
		add_camera('{32'sh7fffffff, 32'sh7fffffff, 0}, '{0, 0, 0}, '{0, 0, 1});
		add_camera('{32'sh80000000, 32'sh80000000, 32'sh80000000}, '{0, 0, 0}, '{1, -1, 1});
		add_camera('{-1, -1, -1}, '{0, 0, 0}, '{-1, -1, -1});
		add_camera('{0, 0, 0}, '{1, 0, 0}, '{0, 0, -1});
		add_camera('{0, 0, 0}, '{0, 0, -32'sh10000}, '{0, -32'sh10000, 0}, 1);
		// random: mostly sane cameras, some full-range noise, some degenerate
		for (int n = 0; n < 1240; n++) begin
			k = $urandom_range(0, 9);
			for (int i = 0; i < 3; i++) begin
				e[i] = rand_coord(k < 3 ? 0 : (k < 8 ? 1 : (k == 8 ? 2 : 3)));
				t[i] = rand_coord(k < 3 ? 0 : (k < 8 ? 1 : (k == 8 ? 2 : 3)));
				u[i] = rand_coord($urandom_range(0, 2));
			end
			case ($urandom_range(0, 15))
				0: t = e;
				1: foreach (u[i]) u[i] = t[i] - e[i];
				2: u = '{0, 0, 0};
				default: ;
			endcase
			add_camera(e, t, u, n == 600);
		end
		stim_done = 1;
	end

	// driver: hold while busy, otherwise present the next item or idle
	always @(negedge clk) begin
		if (!(start && busy) && arst_n) begin
			if (gap > 0) begin
				start <= 0;
				gap <= gap - 1;
			end else if (pending.size() > 0 &&
					!(pending[0].drain && views_due.size() > 0)) begin
				camera_t c;
				c = pending.pop_front();
				start <= 1;
				{eye_x, eye_y, eye_z} <= {c.e[0], c.e[1], c.e[2]};
				{target_x, target_y, target_z} <= {c.t[0], c.t[1], c.t[2]};
				{upref_x, upref_y, upref_z} <= {c.u[0], c.u[1], c.u[2]};
				if (pending.size() > 150 && $urandom_range(0, 15) == 0)
					gap <= $urandom_range(1, 12);
			end else start <= 0;
		end
	end

	// monitor: predict on accept, check on done
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			camera_t c;
			c.e = '{eye_x, eye_y, eye_z};
			c.t = '{target_x, target_y, target_z};
			c.u = '{upref_x, upref_y, upref_z};
			views_due.push_back(view_of(c));
		end
		if (arst_n && done) begin
			if (views_due.size() == 0) begin
				errors++;
				$display("%0t: result with no item pending", $time);
			end else begin
				view_t x, a;
				x = views_due.pop_front();
				a.r = '{right_x, right_y, right_z};
				a.v = '{upaxis_x, upaxis_y, upaxis_z};
				a.g = '{gaze_x, gaze_y, gaze_z};
				a.sh = '{shift_right, shift_up, shift_gaze};
				for (int i = 0; i < 3; i++) begin
					if (a.r[i] !== x.r[i] || a.v[i] !== x.v[i] || a.g[i] !== x.g[i] ||
							a.sh[i] !== x.sh[i]) begin
						errors++;
						$display("%0t: lane %0d expected r=%0d v=%0d g=%0d sh=%0d,",
							$time, i, x.r[i], x.v[i], x.g[i], x.sh[i],
							" got r=%0d v=%0d g=%0d sh=%0d",
							a.r[i], a.v[i], a.g[i], a.sh[i]);
					end
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1;
		wait (stim_done && pending.size() == 0 && views_due.size() == 0);
		repeat (130) @(posedge clk);
		if (errors == 0 && views_due.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
